[design/etm_pkg.sv]
// Shared constants for the exposure tone-map pixel pipeline.
package etm_pkg;

    // Terms of the exp(-f) Taylor series; term one is f itself.
    localparam int SERIES_TERMS = 15;

    // Multiply-by-exp(-1) steps for the integer part of the exponent.
    localparam int POWER_STAGES = 31;

    // Lane depth: gain product, split, three stages per series term after f,
    // power steps, channel quantize.
    localparam int LANE_DEPTH = 2 + 3 * (SERIES_TERMS - 2) + POWER_STAGES + 1;

    // exp(-1) in unsigned Q.32, built with the same truncating series.
    localparam logic [31:0] EXP_NEG_ONE = 32'd1580030169;

    // Reciprocal divide: floor(n / d) = (n * RECIP[d]) >> RECIP_SHIFT, or one more.
    localparam int RECIP_SHIFT = 35;
    localparam logic [34:0] RECIP [2:SERIES_TERMS-1] = '{
        35'd17179869184, 35'd11453246122, 35'd8589934592, 35'd6871947673,
        35'd5726623061,  35'd4908534052,  35'd4294967296, 35'd3817748707,
        35'd3435973836,  35'd3123612578,  35'd2863311530, 35'd2643056797,
        35'd2454267026
    };

    localparam logic [7:0]  ALPHA      = 8'hff;
    localparam logic [15:0] GAIN_RESET = 16'hf000;

endpackage

[design/etm_lane.sv]
// One color channel of the tone-map pipeline: exposure product, exp series, quantize.
module etm_lane #(
    parameter int LIGHT_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [15:0]            gain,
    input  logic signed [LIGHT_WIDTH-1:0] light,
    output logic [7:0]                    chan
);

    localparam int EW = 16 + LIGHT_WIDTH;
    localparam int XW = (EW > 33) ? EW : 33;
    localparam int NT = etm_pkg::SERIES_TERMS - 2;
    localparam int NP = etm_pkg::POWER_STAGES;

    typedef struct packed {
        logic        zero;
        logic        dark;
        logic [4:0]  k;
        logic [31:0] f;
        logic [32:0] sum;
    } ctx_t;

    typedef struct packed {
        logic       zero;
        logic       dark;
        logic [4:0] k;
    } pw_t;

    // exposure product
    logic signed [EW-1:0] gain_x;
    logic signed [EW-1:0] light_x;
    logic signed [EW-1:0] e_reg;

    assign gain_x  = EW'(gain);
    assign light_x = EW'(light);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg <= gain_x * light_x;
        end
    end

    // split magnitude into integer part and Q.32 fraction, take the first term
    logic [EW-1:0] mag;
    logic [XW-1:0] x;
    ctx_t          ctx_next;
    ctx_t          ctx_reg;
    logic [31:0]   term_reg;

    always_comb begin
        mag           = -e_reg;
        x             = XW'(mag);
        ctx_next.zero = ~e_reg[EW-1];
        ctx_next.dark = (x >> 33) != '0;
        ctx_next.k    = x[32:28];
        ctx_next.f    = {x[27:0], 4'b0000};
        ctx_next.sum  = {1'b1, 32'd0} - {1'b0, ctx_next.f};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg  <= ctx_next;
            term_reg <= ctx_next.f;
        end
    end

    // series terms, three stages each
    ctx_t        ctx_in     [NT+1];
    logic [31:0] term_in    [NT+1];
    ctx_t        ctx_a_reg  [NT];
    ctx_t        ctx_b_reg  [NT];
    ctx_t        ctx_c_reg  [NT];
    logic [63:0] prod_a_reg [NT];
    logic [31:0] n_b_reg    [NT];
    logic [66:0] m_b_reg    [NT];
    logic [31:0] term_c_reg [NT];

    assign ctx_in[0]  = ctx_reg;
    assign term_in[0] = term_reg;

    for (genvar t = 0; t < NT; t++) begin : g_term
        localparam int DIV = t + 2;
        logic [31:0] q0;
        logic [31:0] r;
        logic [31:0] q;
        logic [32:0] sum_upd;
        ctx_t        ctx_upd;

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_a_reg[t]  <= ctx_in[t];
                prod_a_reg[t] <= 64'(term_in[t]) * 64'(ctx_in[t].f);
                ctx_b_reg[t]  <= ctx_a_reg[t];
                n_b_reg[t]    <= prod_a_reg[t][63:32];
                m_b_reg[t]    <= 67'(prod_a_reg[t][63:32]) * 67'(etm_pkg::RECIP[DIV]);
            end
        end

        // reciprocal estimate is exact or one low; fix with the remainder
        always_comb begin
            q0 = m_b_reg[t][etm_pkg::RECIP_SHIFT +: 32];
            r  = n_b_reg[t] - q0 * 32'(DIV);
            q  = q0 + 32'(r >= 32'(DIV));
        end

        if ((DIV % 2) == 1) begin : g_odd
            assign sum_upd = ctx_b_reg[t].sum - {1'b0, q};
        end else begin : g_even
            assign sum_upd = ctx_b_reg[t].sum + {1'b0, q};
        end

        always_comb begin
            ctx_upd     = ctx_b_reg[t];
            ctx_upd.sum = sum_upd;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_c_reg[t]  <= ctx_upd;
                term_c_reg[t] <= q;
            end
        end

        assign ctx_in[t+1]  = ctx_c_reg[t];
        assign term_in[t+1] = term_c_reg[t];
    end

    // integer part: one conditional multiply by exp(-1) per stage
    pw_t         pw_in  [NP+1];
    logic [32:0] y_in   [NP+1];
    pw_t         pw_reg [NP];
    logic [32:0] y_reg  [NP];

    assign pw_in[0].zero = ctx_in[NT].zero;
    assign pw_in[0].dark = ctx_in[NT].dark;
    assign pw_in[0].k    = ctx_in[NT].k;
    assign y_in[0]       = ctx_in[NT].sum;

    for (genvar j = 0; j < NP; j++) begin : g_power
        logic [64:0] mul;

        assign mul = 65'(y_in[j]) * 65'(etm_pkg::EXP_NEG_ONE);

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_reg[j] <= pw_in[j];
                y_reg[j]  <= (pw_in[j].k > 5'(j)) ? {1'b0, mul[63:32]} : y_in[j];
            end
        end

        assign pw_in[j+1] = pw_reg[j];
        assign y_in[j+1]  = y_reg[j];
    end

    // quantize: channel = 255 - clamp(ceil(255 * y / 2^32), 1, 255)
    logic [32:0] y_fin;
    logic [40:0] p255;
    logic [40:0] csum;
    logic [8:0]  c9;
    logic [7:0]  c8;
    logic [7:0]  chan_next;
    logic [7:0]  chan_reg;

    always_comb begin
        y_fin = pw_in[NP].dark ? 33'd0 : y_in[NP];
        p255  = {y_fin, 8'd0} - 41'(y_fin);
        csum  = p255 + 41'(32'hffff_ffff);
        c9    = csum[40:32];
        if (c9 == 9'd0) begin
            c8 = 8'd1;
        end else if (c9 > 9'd255) begin
            c8 = 8'd255;
        end else begin
            c8 = c9[7:0];
        end
        chan_next = pw_in[NP].zero ? 8'd0 : (8'd255 - c8);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

[design/exposure_tone_map_pack_unit.sv]
// Path from an accepted request to m_valid: input register, 73 lane stages, output
// register. Throughput: one pixel per cycle while the skid entry is empty; every stage
// of the three channel lanes advances together, and the skid entry at the output lets
// one more result land while the output register waits. Synchronous active-low reset
// clears all valid bits and loads exposure_gain with -1.0; datapath registers carry no reset.
module exposure_tone_map_pack_unit #(
    parameter int LIGHT_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [LIGHT_WIDTH-1:0] s_light_red,
    input  logic signed [LIGHT_WIDTH-1:0] s_light_green,
    input  logic signed [LIGHT_WIDTH-1:0] s_light_blue,
    input  logic                          s_frame_end,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [31:0]                   m_pixel_word,
    output logic                          m_frame_last
);

    localparam int DEPTH = etm_pkg::LANE_DEPTH;

    // exposure gain register; the user writes it only while the pipe is empty, which the block does not enforce
    logic signed [15:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= etm_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // advance the whole pipe while the skid entry is free
    logic en;
    logic skid_valid_reg;

    assign en      = ~skid_valid_reg;
    assign s_ready = en;

    // input register
    logic                          in_valid_reg;
    logic                          in_last_reg;
    logic signed [LIGHT_WIDTH-1:0] red_reg;
    logic signed [LIGHT_WIDTH-1:0] green_reg;
    logic signed [LIGHT_WIDTH-1:0] blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            red_reg     <= s_light_red;
            green_reg   <= s_light_green;
            blue_reg    <= s_light_blue;
            in_last_reg <= s_frame_end;
        end
    end

    // three identical channel lanes
    logic [7:0] red_chan;
    logic [7:0] green_chan;
    logic [7:0] blue_chan;

    etm_lane #(.LIGHT_WIDTH(LIGHT_WIDTH)) u_lane_red (
        .aclk  (aclk),
        .en    (en),
        .gain  (gain_reg),
        .light (red_reg),
        .chan  (red_chan)
    );

    etm_lane #(.LIGHT_WIDTH(LIGHT_WIDTH)) u_lane_green (
        .aclk  (aclk),
        .en    (en),
        .gain  (gain_reg),
        .light (green_reg),
        .chan  (green_chan)
    );

    etm_lane #(.LIGHT_WIDTH(LIGHT_WIDTH)) u_lane_blue (
        .aclk  (aclk),
        .en    (en),
        .gain  (gain_reg),
        .light (blue_reg),
        .chan  (blue_chan)
    );

    // valid and frame flag travel beside the lanes, one entry per lane stage
    logic vld_reg  [DEPTH];
    logic last_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DEPTH; d++) begin
                vld_reg[d] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid_reg;
            for (int d = 1; d < DEPTH; d++) begin
                vld_reg[d] <= vld_reg[d-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg[0] <= in_last_reg;
            for (int d = 1; d < DEPTH; d++) begin
                last_reg[d] <= last_reg[d-1];
            end
        end
    end

    // pack the pixel word at the end of the pipe
    logic [31:0] pipe_word;
    logic        pipe_valid;
    logic        pipe_last;

    assign pipe_word  = {etm_pkg::ALPHA, red_chan, green_chan, blue_chan};
    assign pipe_valid = vld_reg[DEPTH-1];
    assign pipe_last  = last_reg[DEPTH-1];

    // output register plus one skid entry
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_word_reg;
    logic [31:0] out_word_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        skid_valid_next;
    logic [31:0] skid_word_reg;
    logic [31:0] skid_word_next;
    logic        skid_last_reg;
    logic        skid_last_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_last_next  = skid_last_reg;
        if (en) begin
            if (!out_valid_reg || m_ready) begin
                // output free or draining: load straight from the pipe
                out_valid_next = pipe_valid;
                out_word_next  = pipe_word;
                out_last_next  = pipe_last;
            end else if (pipe_valid) begin
                // output stalled: park the arriving result and hold the pipe
                skid_valid_next = 1'b1;
                skid_word_next  = pipe_word;
                skid_last_next  = pipe_last;
            end
        end else if (m_ready) begin
            // drain the skid entry into the output
            out_valid_next  = 1'b1;
            out_word_next   = skid_word_reg;
            out_last_next   = skid_last_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
        skid_word_reg <= skid_word_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_word = out_word_reg;
    assign m_frame_last = out_last_reg;

endmodule

[tb/exposure_tone_map_pack_unit_test.sv]
// Self-checking regression for the exposure tone-map pixel packer.
module exposure_tone_map_pack_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIGHT_BITS = 24;
    localparam int SERIES_TERMS = 15;
    localparam logic [7:0] OPAQUE_ALPHA = 8'hff;
    localparam logic signed [15:0] GAIN_AT_RESET = -16'sd4096;
    localparam logic [15:0] GAIN_MOST_POSITIVE = 16'h7fff;
    localparam logic [15:0] GAIN_MOST_NEGATIVE = 16'h8000;
    localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_PIXELS = 160;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [31:0] pixel_word;
        logic        frame_last;
    } tone_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [15:0]           cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [LIGHT_BITS-1:0] s_light_red = '0;
    logic [LIGHT_BITS-1:0] s_light_green = '0;
    logic [LIGHT_BITS-1:0] s_light_blue = '0;
    logic                  s_frame_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [31:0]           m_pixel_word;
    logic                  m_frame_last;

    // Predictor state: the gain the block holds and exp(-1) in Q.32.
    logic signed [15:0]    gain_shadow = GAIN_AT_RESET;
    logic [63:0]           unit_decay;

    tone_result_t          pending_pixels[$];
    int                    mismatch_count = 0;

    // Receiver stall pattern state.
    int unsigned           stall_mode = 0;
    int unsigned           stall_left = 0;
    int unsigned           cycle_count = 0;

    exposure_tone_map_pack_unit #(
        .LIGHT_WIDTH(LIGHT_BITS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_light_red  (s_light_red),
        .s_light_green(s_light_green),
        .s_light_blue (s_light_blue),
        .s_frame_end  (s_frame_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_word (m_pixel_word),
        .m_frame_last (m_frame_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // exp(-frac) in unsigned Q.32 by a truncating Taylor series; frac may be exactly 1.0.
    function automatic logic [63:0] series_exp_neg(input logic [32:0] frac);
        logic [63:0] term;
        logic [95:0] prod;
        longint      sum;
        int unsigned i;
        term = 64'h1_0000_0000;
        sum = 64'sh1_0000_0000;
        for (i = 1; i < SERIES_TERMS; i++) begin
            prod = term * frac;
            term = (prod >> 32) / i;
            if (i[0]) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    // One channel: 255 - ceil(255 * exp(gain * light)), with the edge clamps.
    function automatic logic [7:0] tone_level(input logic signed [15:0] gain,
                                              input logic signed [LIGHT_BITS-1:0] light);
        longint      exposure;
        logic [63:0] mag;
        logic [63:0] whole;
        logic [63:0] y;
        logic [63:0] c;
        logic [95:0] prod;
        int unsigned step;
        exposure = longint'(gain) * longint'(light);
        if (exposure >= 0) begin
            return 8'd0;
        end
        mag = 64'(-exposure);
        whole = mag >> 28;
        if (whole >= 32) begin
            // Too dark to register: exp rounds to zero.
            y = 64'd0;
        end else begin
            y = series_exp_neg({1'b0, mag[27:0], 4'h0});
            for (step = 0; step < whole; step++) begin
                prod = y * unit_decay;
                y = prod >> 32;
            end
        end
        if (y > 64'h1_0000_0000) begin
            y = 64'h1_0000_0000;
        end
        c = (64'd255 * y + 64'hffff_ffff) >> 32;
        // Keep a strictly negative exponent off full scale, and clamp at unity.
        if (c < 1) begin
            c = 64'd1;
        end
        if (c > 255) begin
            c = 64'd255;
        end
        return 8'(64'd255 - c);
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatch_count < 10) begin
            $display("%0t ns: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
        mismatch_count++;
    endtask

    // Drive one request at the current edge and hold it until it is taken.
    task automatic send_pixel(input logic [LIGHT_BITS-1:0] red,
                              input logic [LIGHT_BITS-1:0] green,
                              input logic [LIGHT_BITS-1:0] blue,
                              input logic frame_end);
        tone_result_t want;
        s_valid <= 1'b1;
        s_light_red <= red;
        s_light_green <= green;
        s_light_blue <= blue;
        s_frame_end <= frame_end;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        want.pixel_word = {OPAQUE_ALPHA, tone_level(gain_shadow, red),
                           tone_level(gain_shadow, green), tone_level(gain_shadow, blue)};
        want.frame_last = frame_end;
        pending_pixels.push_back(want);
    endtask

    task automatic drain_pending();
        while (pending_pixels.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Write the gain only once the pipe holds nothing in flight.
    task automatic set_exposure_gain(input logic [15:0] gain);
        s_valid <= 1'b0;
        drain_pending();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= gain;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_shadow = gain;
    endtask

    // Mix full-range values with magnitudes that land near the interesting exponents.
    function automatic logic [LIGHT_BITS-1:0] random_light();
        logic [LIGHT_BITS-1:0] mag;
        case ($urandom_range(0, 4))
            0, 1: begin
                return LIGHT_BITS'($urandom);
            end
            2, 3: begin
                mag = LIGHT_BITS'($urandom_range(0, 1 << 18));
            end
            default: begin
                mag = LIGHT_BITS'($urandom_range(0, 255));
            end
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Stream random requests in bursts; some calls run gap-free.
    task automatic send_random_pixels(input int count);
        int burst_left;
        int sent;
        bit gaps_on;
        gaps_on = ($urandom_range(0, 3) != 0);
        burst_left = $urandom_range(1, 40);
        for (sent = 0; sent < count; sent++) begin
            send_pixel(random_light(), random_light(), random_light(),
                       ($urandom_range(0, 15) == 0));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if (gaps_on) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    // Reset gain of -1.0: zero/positive products, unity rounding, deep dark, bit patterns.
    task automatic test_reset_gain_directed();
        send_pixel(24'h000000, 24'h000000, 24'h000000, 1'b0);
        send_pixel(24'h000001, 24'hffffff, 24'h000010, 1'b1);
        send_pixel(24'h7fffff, 24'h800000, 24'h200000, 1'b0);
        send_pixel(24'h1fffff, 24'h010000, 24'h008000, 1'b1);
        send_pixel(24'h180000, 24'h0b0000, 24'h000100, 1'b0);
        send_pixel(24'h555555, 24'haaaaaa, 24'h0000ff, 1'b1);
        send_pixel(24'h00ffff, 24'h7f0000, 24'h030000, 1'b0);
        s_valid <= 1'b0;
    endtask

    // Extreme and near-zero gains against extreme light values.
    task automatic test_gain_extremes();
        set_exposure_gain(GAIN_MOST_POSITIVE);
        send_pixel(24'hffffff, 24'hff0000, 24'h800000, 1'b0);
        send_pixel(24'h7fffff, 24'hfffff0, 24'h000001, 1'b1);
        set_exposure_gain(GAIN_MOST_NEGATIVE);
        send_pixel(24'h000001, 24'h7fffff, 24'h010000, 1'b0);
        send_pixel(24'h800000, 24'h000010, 24'h004000, 1'b1);
        set_exposure_gain(16'h0000);
        send_pixel(24'h7fffff, 24'h800000, 24'h000001, 1'b0);
        set_exposure_gain(16'h0001);
        send_pixel(24'hffffff, 24'hff0000, 24'h800000, 1'b1);
        set_exposure_gain(16'hffff);
        send_pixel(24'h000001, 24'h010000, 24'h7fffff, 1'b0);
        s_valid <= 1'b0;
    endtask

    // Random pixels under a sweep of gain settings, extremes included.
    task automatic test_random_gains();
        int phase;
        logic [15:0] gain;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: gain = GAIN_AT_RESET;
                2: gain = GAIN_MOST_NEGATIVE;
                3: gain = -16'($urandom_range(1, 256));
                4: gain = GAIN_MOST_POSITIVE;
                6: gain = 16'($urandom_range(1, 256));
                default: gain = 16'($urandom);
            endcase
            set_exposure_gain(gain);
            send_random_pixels(PHASE_PIXELS);
        end
    endtask

    // Stall the result side on a pattern that changes mode whenever its random countdown runs out.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(32, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((cycle_count % 5) < 2);
        endcase
    end

    // Compare every delivered pixel against the oldest pending prediction.
    always @(posedge aclk) begin
        tone_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch("pixel_word with no request pending", 'x, m_pixel_word);
            end else begin
                want = pending_pixels.pop_front();
                if (m_pixel_word !== want.pixel_word) begin
                    note_mismatch("pixel_word", want.pixel_word, m_pixel_word);
                end
                if (m_frame_last !== want.frame_last) begin
                    note_mismatch("frame_last", 32'(want.frame_last), 32'(m_frame_last));
                end
            end
        end
    end

    initial begin
        unit_decay = series_exp_neg(Q32_ONE);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_gain_directed();
        test_gain_extremes();
        test_random_gains();
        // Let the pipe empty, then hold a little longer for stray results.
        drain_pending();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("exposure_tone_map_pack_unit regression: pass");
        end else begin
            $display("exposure_tone_map_pack_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("exposure_tone_map_pack_unit regression: fail");
        $finish;
    end

endmodule

[files.f]
design/etm_pkg.sv
design/etm_lane.sv
design/exposure_tone_map_pack_unit.sv
tb/exposure_tone_map_pack_unit_test.sv
